/* src/efp_pkg.sv */
package efp_pkg;

    localparam int MAX_ITERATIONS_DEF  = 64;
    localparam int COORD_FRAC_BITS_DEF = 28;

    localparam int ADDR_W = 5;

    localparam logic [2:0] REG_JULIA_MODE = 3'd0;
    localparam logic [2:0] REG_C_REAL     = 3'd1;
    localparam logic [2:0] REG_C_IMAG     = 3'd2;
    localparam logic [2:0] REG_EXPONENT   = 3'd3;
    localparam logic [2:0] REG_PALETTE    = 3'd4;

    localparam logic        RST_JULIA_MODE = 1'b0;
    localparam logic [31:0] RST_C_REAL     = 32'd80530637;
    localparam logic [31:0] RST_C_IMAG     = 32'd2684355;
    localparam logic [2:0]  RST_EXPONENT   = 3'd2;
    localparam logic [2:0]  RST_PALETTE    = 3'd1;

    localparam logic [2:0] PAL_RED   = 3'd0;
    localparam logic [2:0] PAL_GREEN = 3'd1;
    localparam logic [2:0] PAL_BLUE  = 3'd2;
    localparam logic [2:0] PAL_GRAY  = 3'd3;
    localparam logic [2:0] PAL_MIXED = 3'd4;
    localparam logic [2:0] PAL_RAMP  = 3'd5;

    typedef struct packed {
        logic        julia_mode;
        logic [31:0] c_real;
        logic [31:0] c_imag;
        logic [2:0]  exponent;
        logic [2:0]  palette;
    } efp_cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TEST,
        ST_WAIT,
        ST_ESC,
        ST_POW_NEXT,
        ST_STORE_T,
        ST_STORE_AI,
        ST_UPDATE,
        ST_COLOUR
    } efp_state_t;

    // Products of one iteration: squares for the escape test, then the
    // four cross products of one power step.
    typedef enum logic [2:0] {
        OP_SQX,
        OP_SQY,
        OP_XAR,
        OP_YAI,
        OP_XAI,
        OP_ARY
    } mul_op_t;

    typedef struct packed {
        logic    load_point;
        logic    mul_start;
        mul_op_t start_op;
        mul_op_t done_op;
        logic    init_pow;
        logic    store_t;
        logic    store_ai;
        logic    update_z;
        logic    out_load;
    } efp_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic escaped;
        logic sat;
        logic count_max;
    } efp_status_t;

    // Remainder of an 8-bit level by a small constant modulus.
    function automatic logic [7:0] col_mod(input logic [7:0] v, input logic [7:0] m);
        logic [7:0] r;
        int unsigned step;
        r = v;
        for (int i = 1; i <= 25; i++) begin
            step = i * m;
            if (step <= 32'(v)) begin
                r = 8'(32'(v) - step);
            end
        end
        return r;
    endfunction

    function automatic logic [18:0] pal_colour(input logic [7:0] col, input logic [2:0] sel);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = 8'd0;
        g = 8'd0;
        b = 8'd0;
        case (sel)
            PAL_RED: r = col;
            PAL_GREEN: g = {2'b00, col[5:0]};
            PAL_BLUE: b = {3'b000, col[4:0]};
            PAL_GRAY:
            begin
                r = col_mod(col, 8'd50);
                g = {r[6:0], 1'b0};
                b = r;
            end
            PAL_MIXED:
            begin
                r = col_mod(col, 8'd60);
                g = col_mod(col, 8'd40);
                b = col_mod(col, 8'd10);
            end
            PAL_RAMP:
            begin
                if (col < 8'd33) begin
                    r = col;
                end else if (col < 8'd200) begin
                    g = {2'b00, col[5:0]};
                end else begin
                    b = col - 8'd200;
                end
            end
            default: r = 8'd0;
        endcase
        return (19'(r) << 11) | (19'(g) << 5) | 19'(b);
    endfunction

endpackage

/* src/efp_regs.sv */
module efp_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [efp_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output efp_pkg::efp_cfg_t           cfg
);
    import efp_pkg::*;

    efp_cfg_t   cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.julia_mode <= RST_JULIA_MODE;
            cfg_reg.c_real     <= RST_C_REAL;
            cfg_reg.c_imag     <= RST_C_IMAG;
            cfg_reg.exponent   <= RST_EXPONENT;
            cfg_reg.palette    <= RST_PALETTE;
        end else if (wr_en) begin
            case (reg_idx)
                REG_JULIA_MODE: cfg_reg.julia_mode <= pwdata[0];
                REG_C_REAL:     cfg_reg.c_real     <= pwdata;
                REG_C_IMAG:     cfg_reg.c_imag     <= pwdata;
                REG_EXPONENT:   cfg_reg.exponent   <= pwdata[2:0];
                REG_PALETTE:    cfg_reg.palette    <= pwdata[2:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_JULIA_MODE: prdata = {31'd0, cfg_reg.julia_mode};
            REG_C_REAL:     prdata = cfg_reg.c_real;
            REG_C_IMAG:     prdata = cfg_reg.c_imag;
            REG_EXPONENT:   prdata = {29'd0, cfg_reg.exponent};
            REG_PALETTE:    prdata = {29'd0, cfg_reg.palette};
            default:        prdata = 32'd0;
        endcase
    end

endmodule

/* src/efp_mul.sv */
module efp_mul #(
    parameter int VW = 35,
    parameter int F  = 28
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [VW-1:0] a,
    input  logic signed [VW-1:0] b,
    input  logic                 cap_sq,
    output logic                 done,
    output logic signed [F+11:0] p,
    output logic                 sat
);
    localparam int DW   = 16;
    localparam int ND   = (VW + DW - 1) / DW;
    localparam int BW   = ND * DW;
    localparam int ACCW = BW + VW;
    localparam int RW   = F + 12;
    localparam int SHW  = ACCW - F;
    localparam int CNTW = $clog2(ND);

    localparam logic [SHW-1:0] CAP_SQ  = SHW'(1) << (F + 10);
    localparam logic [SHW-1:0] CAP_LIM = SHW'(1) << (F + 5);

    logic [VW-1:0]    a_mag;
    logic [VW-1:0]    b_mag;
    logic [VW-1:0]    a_reg;
    logic [BW-1:0]    b_reg;
    logic [ACCW-1:0]  acc_reg;
    logic             neg_reg;
    logic             sq_reg;
    logic [CNTW-1:0]  cnt_reg;
    logic             busy_reg;
    logic             fin_reg;
    logic             done_reg;
    logic signed [RW-1:0] p_reg;
    logic             sat_reg;

    logic [VW+DW-1:0] pp;
    logic [SHW-1:0]   r_mag;
    logic [SHW-1:0]   cap;
    logic             over;
    logic [RW-1:0]    m_ext;

    assign a_mag = a[VW-1] ? (~a + 1'b1) : a;
    assign b_mag = b[VW-1] ? (~b + 1'b1) : b;

    // One 16-bit digit of b per cycle, most significant first.
    assign pp    = a_reg * b_reg[BW-1 -: DW];
    assign r_mag = acc_reg[ACCW-1:F];
    assign cap   = sq_reg ? CAP_SQ : CAP_LIM;
    assign over  = r_mag > cap;
    assign m_ext = over ? RW'(cap) : RW'(r_mag);

    assign done = done_reg;
    assign p    = p_reg;
    assign sat  = sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNTW'(ND - 1)) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end else if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg) begin
            acc_reg <= (acc_reg << DW) + ACCW'(pp);
            b_reg   <= b_reg << DW;
        end else if (start) begin
            a_reg   <= a_mag;
            b_reg   <= BW'(b_mag);
            acc_reg <= '0;
            neg_reg <= a[VW-1] ^ b[VW-1];
            sq_reg  <= cap_sq;
        end
        if (fin_reg) begin
            p_reg   <= neg_reg ? signed'(~m_ext + 1'b1) : signed'(m_ext);
            sat_reg <= over;
        end
    end

endmodule

/* src/efp_dp.sv */
module efp_dp #(
    parameter int MAX_ITERATIONS  = 64,
    parameter int COORD_FRAC_BITS = 28
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [31:0]           point_real,
    input  logic [31:0]           point_imag,
    input  efp_pkg::efp_cfg_t     cfg,
    input  efp_pkg::efp_cmd_t     cmd,
    output efp_pkg::efp_status_t  status,
    output logic [6:0]            escape_count,
    output logic [18:0]           pixel_colour
);
    import efp_pkg::*;

    localparam int F   = COORD_FRAC_BITS;
    localparam int VW  = (F + 7 > 32) ? F + 7 : 32;
    localparam int RW  = F + 12;
    localparam int AW  = RW + 1;
    localparam int SW  = (VW + 1 > AW) ? VW + 1 : AW;
    localparam int CW  = $clog2(MAX_ITERATIONS + 1);
    localparam int RMW = (MAX_ITERATIONS > 1) ? $clog2(MAX_ITERATIONS) : 1;
    localparam int Q_STEP = 255 / MAX_ITERATIONS;
    localparam int R_STEP = 255 % MAX_ITERATIONS;

    localparam logic signed [SW-1:0] LIM_S  = SW'(1) << (F + 5);
    localparam logic signed [SW-1:0] NLIM_S = -LIM_S;
    localparam logic signed [AW-1:0] ESC_A  = AW'(100) << F;
    localparam logic [RMW:0]         MAX_R  = (RMW + 1)'(MAX_ITERATIONS);

    function automatic logic signed [VW-1:0] clamp(input logic signed [SW-1:0] v);
        if (v > LIM_S) begin
            return VW'(LIM_S);
        end else if (v < NLIM_S) begin
            return VW'(NLIM_S);
        end
        return VW'(v);
    endfunction

    function automatic logic over_lim(input logic signed [SW-1:0] v);
        return (v > LIM_S) || (v < NLIM_S);
    endfunction

    logic signed [VW-1:0] x_reg, y_reg, ar_reg, ai_reg, t_reg, cr_reg, ci_reg;
    logic signed [AW-1:0] acc_reg;
    logic                 big_reg;
    logic                 sat_reg;
    logic [CW-1:0]        count_reg;
    logic [7:0]           q_reg;
    logic [RMW-1:0]       rem_reg;
    logic [6:0]           count_out_reg;
    logic [18:0]          colour_out_reg;

    logic signed [31:0]   pr_s, pi_s, jr_s, ji_s;
    logic signed [VW-1:0] mul_a, mul_b;
    logic                 mul_sq;
    logic                 mul_done;
    logic signed [RW-1:0] mul_p;
    logic                 mul_sat;
    logic signed [AW-1:0] p_ext;
    logic signed [SW-1:0] acc_s;
    logic signed [SW-1:0] sum_x, sum_y;
    logic [RMW:0]         rem_sum;
    logic                 rem_wrap;
    logic [7:0]           col;

    assign pr_s = signed'(point_real);
    assign pi_s = signed'(point_imag);
    assign jr_s = signed'(cfg.c_real);
    assign ji_s = signed'(cfg.c_imag);

    always_comb
    begin
        mul_a  = x_reg;
        mul_b  = x_reg;
        mul_sq = 1'b0;
        case (cmd.start_op)
            OP_SQX:
            begin
                mul_a  = x_reg;
                mul_b  = x_reg;
                mul_sq = 1'b1;
            end
            OP_SQY:
            begin
                mul_a  = y_reg;
                mul_b  = y_reg;
                mul_sq = 1'b1;
            end
            OP_XAR:
            begin
                mul_a = x_reg;
                mul_b = ar_reg;
            end
            OP_YAI:
            begin
                mul_a = y_reg;
                mul_b = ai_reg;
            end
            OP_XAI:
            begin
                mul_a = x_reg;
                mul_b = ai_reg;
            end
            OP_ARY:
            begin
                mul_a = ar_reg;
                mul_b = y_reg;
            end
            default:
            begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
        endcase
    end

    efp_mul #(
        .VW (VW),
        .F  (F)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .cap_sq (mul_sq),
        .done   (mul_done),
        .p      (mul_p),
        .sat    (mul_sat)
    );

    assign p_ext    = AW'(mul_p);
    assign acc_s    = SW'(acc_reg);
    assign sum_x    = SW'(ar_reg) + SW'(cr_reg);
    assign sum_y    = SW'(ai_reg) + SW'(ci_reg);
    assign rem_sum  = {1'b0, rem_reg} + (RMW + 1)'(R_STEP);
    assign rem_wrap = rem_sum >= MAX_R;
    assign col      = 8'd255 - q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            big_reg <= 1'b0;
            sat_reg <= 1'b0;
        end else begin
            if (cmd.load_point) begin
                sat_reg <= 1'b0;
            end else begin
                if (mul_done) begin
                    case (cmd.done_op)
                        OP_SQX: big_reg <= mul_sat;
                        OP_SQY: big_reg <= big_reg | mul_sat;
                        default: sat_reg <= sat_reg | mul_sat;
                    endcase
                end
                if ((cmd.store_t || cmd.store_ai) && over_lim(acc_s)) begin
                    sat_reg <= 1'b1;
                end
                if (cmd.update_z && (over_lim(sum_x) || over_lim(sum_y))) begin
                    sat_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_point) begin
            if (cfg.julia_mode) begin
                x_reg  <= VW'(pr_s);
                y_reg  <= VW'(pi_s);
                cr_reg <= VW'(jr_s);
                ci_reg <= VW'(ji_s);
            end else begin
                x_reg  <= '0;
                y_reg  <= '0;
                cr_reg <= VW'(pr_s);
                ci_reg <= VW'(pi_s);
            end
            count_reg <= '0;
            q_reg     <= 8'd0;
            rem_reg   <= '0;
        end
        if (mul_done) begin
            case (cmd.done_op)
                OP_SQY,
                OP_ARY:  acc_reg <= acc_reg + p_ext;
                OP_YAI:  acc_reg <= acc_reg - p_ext;
                default: acc_reg <= p_ext;
            endcase
        end
        if (cmd.init_pow) begin
            ar_reg <= x_reg;
            ai_reg <= y_reg;
        end
        if (cmd.store_t) begin
            t_reg <= clamp(acc_s);
        end
        if (cmd.store_ai) begin
            ai_reg <= clamp(acc_s);
            ar_reg <= t_reg;
        end
        if (cmd.update_z) begin
            x_reg     <= clamp(sum_x);
            y_reg     <= clamp(sum_y);
            count_reg <= count_reg + 1'b1;
            // count*255/MAX kept as a running quotient and remainder
            rem_reg   <= rem_wrap ? RMW'(rem_sum - MAX_R) : RMW'(rem_sum);
            q_reg     <= q_reg + 8'(Q_STEP) + {7'd0, rem_wrap};
        end
        if (cmd.out_load) begin
            count_out_reg  <= 7'(count_reg);
            colour_out_reg <= pal_colour(col, cfg.palette);
        end
    end

    assign status.mul_done  = mul_done;
    assign status.escaped   = big_reg || (acc_reg > ESC_A);
    assign status.sat       = sat_reg;
    assign status.count_max = count_reg >= CW'(MAX_ITERATIONS);

    assign escape_count = count_out_reg;
    assign pixel_colour = colour_out_reg;

endmodule

/* src/efp_ctrl.sv */
module efp_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [2:0]            exponent,
    input  efp_pkg::efp_status_t  status,
    output efp_pkg::efp_cmd_t     cmd
);
    import efp_pkg::*;

    efp_state_t state_reg, state_next;
    mul_op_t    op_reg, op_next;
    logic [2:0] k_reg, k_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_SQX;
            k_reg         <= 3'd0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid) begin
                    state_next = ST_TEST;
                end
            end
            ST_TEST:
            begin
                if (status.count_max || status.sat) begin
                    state_next = ST_COLOUR;
                end else begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (status.mul_done) begin
                    case (op_reg)
                        OP_SQY:  state_next = ST_ESC;
                        OP_YAI:  state_next = ST_STORE_T;
                        OP_ARY:  state_next = ST_STORE_AI;
                        default: state_next = ST_WAIT;
                    endcase
                end
            end
            ST_ESC:
            begin
                state_next = status.escaped ? ST_COLOUR : ST_POW_NEXT;
            end
            ST_POW_NEXT:
            begin
                state_next = (k_reg < exponent) ? ST_WAIT : ST_UPDATE;
            end
            ST_STORE_T:  state_next = ST_WAIT;
            ST_STORE_AI: state_next = ST_POW_NEXT;
            ST_UPDATE:   state_next = ST_TEST;
            ST_COLOUR:
            begin
                if (!out_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.start_op = OP_SQX;
        cmd.done_op  = op_reg;
        op_next      = op_reg;
        k_next       = k_reg;
        s_tready     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready       = 1'b1;
                cmd.load_point = s_tvalid;
            end
            ST_TEST:
            begin
                if (!(status.count_max || status.sat)) begin
                    cmd.mul_start = 1'b1;
                    cmd.start_op  = OP_SQX;
                    op_next       = OP_SQX;
                end
            end
            ST_WAIT:
            begin
                if (status.mul_done) begin
                    // chain the second product of each pair straight away
                    case (op_reg)
                        OP_SQX:
                        begin
                            cmd.mul_start = 1'b1;
                            cmd.start_op  = OP_SQY;
                            op_next       = OP_SQY;
                        end
                        OP_XAR:
                        begin
                            cmd.mul_start = 1'b1;
                            cmd.start_op  = OP_YAI;
                            op_next       = OP_YAI;
                        end
                        OP_XAI:
                        begin
                            cmd.mul_start = 1'b1;
                            cmd.start_op  = OP_ARY;
                            op_next       = OP_ARY;
                        end
                        default: cmd.mul_start = 1'b0;
                    endcase
                end
            end
            ST_ESC:
            begin
                if (!status.escaped) begin
                    cmd.init_pow = 1'b1;
                    k_next       = 3'd1;
                end
            end
            ST_POW_NEXT:
            begin
                if (k_reg < exponent) begin
                    cmd.mul_start = 1'b1;
                    cmd.start_op  = OP_XAR;
                    op_next       = OP_XAR;
                end
            end
            ST_STORE_T:
            begin
                cmd.store_t   = 1'b1;
                cmd.mul_start = 1'b1;
                cmd.start_op  = OP_XAI;
                op_next       = OP_XAI;
            end
            ST_STORE_AI:
            begin
                cmd.store_ai = 1'b1;
                k_next       = k_reg + 3'd1;
            end
            ST_UPDATE:   cmd.update_z = 1'b1;
            ST_COLOUR:   cmd.out_load = !out_valid_reg || m_tready;
            default:     cmd.load_point = 1'b0;
        endcase
    end

    // Hold the result until the downstream transfer completes.
    always_comb
    begin
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

/* src/escape_time_fractal_pixel.sv */
// Channel   Direction  Payload
// s_axis    in         tdata[31:0] point_real, tdata[63:32] point_imag
// m_axis    out        tdata[6:0] escape_count, tdata[25:7] pixel_colour
// apb       in/out     julia_mode, julia_c_real, julia_c_imag, exponent, palette_select
//
// One point at a time. Each iteration runs on one shared multiplier that
// forms each product one 16-bit digit at a time, ND = ceil(value width / 16)
// digits, 3 by default. A power below two acts as one. A point runs for up
// to MAX_ITERATIONS iterations and then is coloured.
// rst_n clears the controller and the registers to their documented values.
// A finished result waits in the output register while the next point loads.
module escape_time_fractal_pixel #(
    parameter int MAX_ITERATIONS  = efp_pkg::MAX_ITERATIONS_DEF,
    parameter int COORD_FRAC_BITS = efp_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [63:0]                s_tdata,  // point_real, point_imag
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata,  // escape_count, pixel_colour, zero pad
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [efp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import efp_pkg::*;

    efp_cfg_t    cfg;
    efp_cmd_t    cmd;
    efp_status_t status;
    logic [6:0]  escape_count;
    logic [18:0] pixel_colour;

    efp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    efp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .exponent (cfg.exponent),
        .status   (status),
        .cmd      (cmd)
    );

    efp_dp #(
        .MAX_ITERATIONS  (MAX_ITERATIONS),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_real   (s_tdata[31:0]),
        .point_imag   (s_tdata[63:32]),
        .cfg          (cfg),
        .cmd          (cmd),
        .status       (status),
        .escape_count (escape_count),
        .pixel_colour (pixel_colour)
    );

    assign m_tdata = {6'd0, pixel_colour, escape_count};

    // A new result never overwrites one that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result register overwritten");

    // The multiplier cannot finish in the cycle right after a start.
    a_mul_latency: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_start |=> !status.mul_done)
        else $error("multiplier finished too early");

    // No point is taken while a product is still in flight.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        status.mul_done |-> !s_tready)
        else $error("input accepted during an iteration");

endmodule

/* test/escape_time_fractal_pixel_checker.sv */
`timescale 1ns / 1ps

module escape_time_fractal_pixel_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [63:0]                s_tdata,   // point_real, point_imag
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [31:0]                m_tdata,   // escape_count, pixel_colour, zero pad
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [efp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    input  logic [31:0]                prdata,
    input  logic                       pready,
    output int                         failures,
    output int                         pending,
    output int                         results_checked,
    output int                         never_escaped
);
    import efp_pkg::*;

    localparam int     FRAC      = COORD_FRAC_BITS_DEF;
    localparam int     MAX_IT    = MAX_ITERATIONS_DEF;
    localparam longint ONE_FX    = 64'sd1 << FRAC;
    localparam longint BOUND_FX  = 32 * ONE_FX;
    localparam longint SQ_CAP_FX = 1024 * ONE_FX;
    localparam longint ESCAPE_FX = 100 * ONE_FX;

    typedef struct packed {
        logic [6:0]  escape_count;
        logic [18:0] pixel_colour;
    } pixel_result_t;

    efp_cfg_t      regs;
    pixel_result_t expected_pixels[$];

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns mismatch: %s got 0x%0h want 0x%0h", $time, what, got, want);
        failures++;
    endtask

    // Exact product, magnitude truncated and clamped to cap; clamping marks the point.
    function automatic longint fx_product(input longint a, input longint b, input longint cap,
                                          inout bit clipped);
        logic [127:0] ma;
        logic [127:0] mb;
        logic [127:0] prod;
        longint       mag;
        ma   = (a < 0) ? 128'(-a) : 128'(a);
        mb   = (b < 0) ? 128'(-b) : 128'(b);
        prod = (ma * mb) >> FRAC;
        if (prod > 128'(cap)) begin
            clipped = 1'b1;
            mag     = cap;
        end else begin
            mag = longint'(prod[63:0]);
        end
        return ((a < 0) != (b < 0)) ? -mag : mag;
    endfunction

    function automatic longint fx_clamp(input longint v, inout bit clipped);
        if (v > BOUND_FX) begin
            clipped = 1'b1;
            return BOUND_FX;
        end
        if (v < -BOUND_FX) begin
            clipped = 1'b1;
            return -BOUND_FX;
        end
        return v;
    endfunction

    function automatic pixel_result_t escape_time(input efp_cfg_t setup,
                                                  input logic signed [31:0] pr,
                                                  input logic signed [31:0] pi);
        pixel_result_t res;
        longint        x;
        longint        y;
        longint        cr;
        longint        ci;
        longint        ar;
        longint        ai;
        longint        t;
        longint        p1;
        longint        p2;
        longint        mag2;
        bit            clipped;
        bit            over;
        bit            done;
        int            iter;
        int            level;
        int            red;
        int            green;
        int            blue;
        x       = 0;
        y       = 0;
        cr      = longint'(pr);
        ci      = longint'(pi);
        clipped = 1'b0;
        done    = 1'b0;
        iter    = 0;
        if (setup.julia_mode) begin
            x  = longint'(pr);
            y  = longint'(pi);
            cr = longint'($signed(setup.c_real));
            ci = longint'($signed(setup.c_imag));
        end
        while (!done) begin
            if (iter >= MAX_IT) begin
                iter = MAX_IT;
                done = 1'b1;
            end else if (clipped) begin
                // a point clamped during the last iteration counts as escaped
                done = 1'b1;
            end else begin
                over = 1'b0;
                p1   = fx_product(x, x, SQ_CAP_FX, over);
                p2   = fx_product(y, y, SQ_CAP_FX, over);
                mag2 = p1 + p2;
                if (over || mag2 > ESCAPE_FX) begin
                    done = 1'b1;
                end else begin
                    ar = x;
                    ai = y;
                    for (int k = 1; k < int'(setup.exponent); k++) begin
                        p1 = fx_product(x, ar, BOUND_FX, clipped);
                        p2 = fx_product(y, ai, BOUND_FX, clipped);
                        t  = fx_clamp(p1 - p2, clipped);
                        p1 = fx_product(x, ai, BOUND_FX, clipped);
                        p2 = fx_product(ar, y, BOUND_FX, clipped);
                        ai = fx_clamp(p1 + p2, clipped);
                        ar = t;
                    end
                    x = fx_clamp(ar + cr, clipped);
                    y = fx_clamp(ai + ci, clipped);
                    iter++;
                end
            end
        end
        level = (255 - (iter * 255) / MAX_IT) & 8'hff;
        red   = 0;
        green = 0;
        blue  = 0;
        case (setup.palette)
            PAL_RED: red = level;
            PAL_GREEN: green = level % 64;
            PAL_BLUE: blue = level % 32;
            PAL_GRAY:
            begin
                red   = level % 50;
                green = red * 2;
                blue  = red;
            end
            PAL_MIXED:
            begin
                red   = level % 60;
                green = level % 40;
                blue  = level % 10;
            end
            PAL_RAMP:
            begin
                if (level < 33) begin
                    red = level;
                end else if (level < 200) begin
                    green = level % 64;
                end else begin
                    blue = level - 200;
                end
            end
            default: red = 0;
        endcase
        res.escape_count = 7'(iter);
        res.pixel_colour = 19'((red << 11) | (green << 5) | blue);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_result_t want;
        logic [31:0]   reg_value;
        bit            mapped;
        if (!rst_n) begin
            expected_pixels.delete();
            regs.julia_mode <= RST_JULIA_MODE;
            regs.c_real     <= RST_C_REAL;
            regs.c_imag     <= RST_C_IMAG;
            regs.exponent   <= RST_EXPONENT;
            regs.palette    <= RST_PALETTE;
            pending         <= 0;
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr[4:2])
                        REG_JULIA_MODE: regs.julia_mode <= pwdata[0];
                        REG_C_REAL: regs.c_real <= pwdata;
                        REG_C_IMAG: regs.c_imag <= pwdata;
                        REG_EXPONENT: regs.exponent <= pwdata[2:0];
                        REG_PALETTE: regs.palette <= pwdata[2:0];
                        default: ;
                    endcase
                end else begin
                    mapped = 1'b1;
                    case (paddr[4:2])
                        REG_JULIA_MODE: reg_value = {31'd0, regs.julia_mode};
                        REG_C_REAL: reg_value = regs.c_real;
                        REG_C_IMAG: reg_value = regs.c_imag;
                        REG_EXPONENT: reg_value = {29'd0, regs.exponent};
                        REG_PALETTE: reg_value = {29'd0, regs.palette};
                        default:
                        begin
                            mapped    = 1'b0;
                            reg_value = 32'd0;
                        end
                    endcase
                    if (mapped && prdata !== reg_value) begin
                        report_mismatch($sformatf("register read at 0x%0h", paddr),
                                        prdata, reg_value);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_pixels.push_back(escape_time(regs, s_tdata[31:0], s_tdata[63:32]));
            end
            if (m_tvalid && m_tready) begin
                if (expected_pixels.size() == 0) begin
                    report_mismatch("result transfer with no point pending", m_tdata, 0);
                end else begin
                    want = expected_pixels.pop_front();
                    if (m_tdata[6:0] !== want.escape_count) begin
                        report_mismatch("escape_count", m_tdata[6:0], want.escape_count);
                    end
                    if (m_tdata[25:7] !== want.pixel_colour) begin
                        report_mismatch("pixel_colour", m_tdata[25:7], want.pixel_colour);
                    end
                    if (m_tdata[31:26] !== 6'd0) begin
                        report_mismatch("tdata pad bits", m_tdata[31:26], 0);
                    end
                    results_checked <= results_checked + 1;
                    if (want.escape_count == 7'(MAX_IT)) begin
                        never_escaped <= never_escaped + 1;
                    end
                end
            end
            pending <= expected_pixels.size();
        end
    end

endmodule

/* test/escape_time_fractal_pixel_tb.sv */
`timescale 1ns / 1ps

module escape_time_fractal_pixel_tb;
    import efp_pkg::*;

    // palette codes with no colour assigned
    localparam logic [2:0] PAL_UNUSED_A = 3'd6;
    localparam logic [2:0] PAL_UNUSED_B = 3'd7;

    localparam logic [31:0] Q_MAX   = 32'h7fff_ffff;
    localparam logic [31:0] Q_MIN   = 32'h8000_0000;
    localparam logic [31:0] Q_ONE   = 32'h1000_0000;
    localparam logic [31:0] Q_M_ONE = 32'hf000_0000;
    localparam logic [31:0] Q_SEVEN = 32'h7000_0000;
    localparam logic [31:0] Q_M_7   = 32'h9000_0000;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [63:0]       s_tdata;   // point_real, point_imag
    logic              m_tvalid;
    logic              m_tready;
    logic [31:0]       m_tdata;   // escape_count, pixel_colour, zero pad
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    int failures;
    int pending;
    int results_checked;
    int never_escaped;
    int send_idle_pct;
    int ready_idle_pct;

    escape_time_fractal_pixel i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    escape_time_fractal_pixel_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .failures        (failures),
        .pending         (pending),
        .results_checked (results_checked),
        .never_escaped   (never_escaped)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= ready_idle_pct);
    end

    initial
    begin
        #200_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_point(input logic [31:0] re, input logic [31:0] im);
        int gap;
        gap = 0;
        while (gap < 200 && $urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {im, re};
        do @(posedge clk); while (!s_tready);
    endtask

    // Hold the sender until every pending result has come back.
    task automatic drain_points();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic reg_access(input logic write_en, input logic [2:0] idx,
                              input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write_en;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    task automatic apply_setup(input logic mode, input logic [31:0] c_re,
                               input logic [31:0] c_im, input logic [2:0] power,
                               input logic [2:0] palette_code);
        drain_points();
        reg_access(1'b1, REG_JULIA_MODE, {31'($urandom()), mode});
        reg_access(1'b1, REG_C_REAL, c_re);
        reg_access(1'b1, REG_C_IMAG, c_im);
        reg_access(1'b1, REG_EXPONENT, {29'($urandom()), power});
        reg_access(1'b1, REG_PALETTE, {29'($urandom()), palette_code});
        for (int i = 0; i <= int'(REG_PALETTE); i++) begin
            reg_access(1'b0, 3'(i), 32'd0);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Signed Q4.28 value drawn uniformly from [-span, span].
    function automatic logic [31:0] around_zero(input int unsigned span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic logic [31:0] far_coord();
        logic [31:0] mag;
        mag = $urandom_range(32'h5000_0000, Q_MAX);
        return $urandom_range(1) ? mag : -mag;
    endfunction

    task automatic random_points(input int count);
        int kind;
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(99);
            if (kind < 35) begin
                send_point($urandom(), $urandom());
            end else if (kind < 75) begin
                send_point(around_zero(32'h2400_0000), around_zero(32'h2400_0000));
            end else if (kind < 90) begin
                send_point(around_zero(Q_ONE), around_zero(Q_ONE));
            end else begin
                send_point(far_coord(), far_coord());
            end
            if ($urandom_range(59) == 0) begin
                drain_points();
            end
        end
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        s_tvalid       <= 1'b0;
        s_tdata        <= 64'd0;
        m_tready       <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= 32'd0;
        send_idle_pct  = 30;
        ready_idle_pct = 84;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset setup: Mandelbrot, square, green
        send_point(32'd0, 32'd0);
        send_point(Q_MIN, Q_MIN);
        send_point(Q_MAX, Q_MAX);
        send_point(Q_MIN, Q_MAX);
        send_point(Q_SEVEN, Q_SEVEN);
        send_point(Q_SEVEN, Q_M_7);
        send_point(Q_M_ONE, 32'd0);
        send_point(32'h0400_0000, 32'd0);
        send_point(32'hf400_0000, 32'h0199_999a);
        send_point(32'd1, 32'hffff_ffff);
        send_point(32'he000_0000, 32'd0);
        send_point(32'h04cc_cccd, 32'h0800_0000);

        // exponents below two just add c; palettes with no colour
        apply_setup(1'b1, Q_MIN, Q_MAX, 3'd0, PAL_UNUSED_A);
        send_point(32'd0, 32'd0);
        send_point(Q_MIN, Q_MAX);
        apply_setup(1'b1, Q_MAX, Q_MIN, 3'd1, PAL_UNUSED_B);
        send_point(Q_ONE, Q_ONE);
        send_point(Q_M_ONE, Q_M_ONE);

        // highest power; clamped products make a large point such as (7, 7) escape
        apply_setup(1'b1, RST_C_REAL, RST_C_IMAG, 3'd7, PAL_RED);
        send_point(32'd0, 32'd0);
        send_point(32'h0800_0000, 32'hf800_0000);
        send_point(Q_SEVEN, Q_SEVEN);
        apply_setup(1'b0, RST_C_REAL, RST_C_IMAG, 3'd5, PAL_RAMP);
        send_point(32'd0, 32'd0);
        send_point(32'he800_0000, 32'd0);
        send_point(32'h0666_6666, 32'h04cc_cccd);

        apply_setup(1'b0, RST_C_REAL, RST_C_IMAG, 3'd2, PAL_RED);
        random_points(75);
        apply_setup(1'b1, around_zero(Q_ONE), around_zero(Q_ONE), 3'd3, PAL_BLUE);
        random_points(75);

        send_idle_pct  = 84;
        ready_idle_pct = 30;
        apply_setup(1'b0, $urandom(), $urandom(), 3'd4, PAL_GRAY);
        random_points(75);
        apply_setup(1'b1, $urandom(), $urandom(), 3'd7, PAL_MIXED);
        random_points(75);

        send_idle_pct  = 0;
        ready_idle_pct = 0;
        apply_setup(1'b0, RST_C_REAL, RST_C_IMAG, 3'd5, PAL_RAMP);
        random_points(75);
        apply_setup(1'b1, Q_MIN, Q_MAX, 3'd6, PAL_GREEN);
        random_points(75);

        drain_points();
        repeat (100) @(posedge clk);
        $display("Checked %0d pixels, %0d of them never escaped, in both fractal modes,",
                 results_checked, never_escaped);
        $display("with powers 0 to 7, all palette codes and three idling patterns.");
        if (failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
